// ===== rtl/sfe_pkg.sv =====
// Shared types and constants of the sprite framebuffer engine.
// Used by sfe_row_unit, sprite_framebuffer_engine_unit and the testbench; depends on nothing.
package sfe_pkg;

    // Screen geometry
    localparam int COLS        = 128;
    localparam int ROWS        = 64;
    localparam int LOW_COLS    = 64;
    localparam int LOW_ROWS    = 32;
    localparam int SIDE_SCROLL = 4;
    localparam int SPRITE_W    = 16;

    localparam int ROW_AW = $clog2(ROWS);
    localparam int COL_AW = $clog2(COLS);
    localparam int EXT_W  = COLS + SPRITE_W;

    // Command codes
    localparam logic [3:0] CMD_CLEAR     = 4'd0;
    localparam logic [3:0] CMD_LOW_RES   = 4'd1;
    localparam logic [3:0] CMD_HIGH_RES  = 4'd2;
    localparam logic [3:0] CMD_SCROLL_DN = 4'd3;
    localparam logic [3:0] CMD_SCROLL_UP = 4'd4;
    localparam logic [3:0] CMD_SCROLL_RT = 4'd5;
    localparam logic [3:0] CMD_SCROLL_LT = 4'd6;
    localparam logic [3:0] CMD_DRAW      = 4'd7;
    localparam logic [3:0] CMD_READ      = 4'd8;

    // Row unit operations
    localparam logic [1:0] ROP_COPY  = 2'd0;
    localparam logic [1:0] ROP_RIGHT = 2'd1;
    localparam logic [1:0] ROP_LEFT  = 2'd2;
    localparam logic [1:0] ROP_DRAW  = 2'd3;

    // Control from the sequencer to the row unit
    typedef struct packed {
        logic [1:0]          op;
        logic                high;
        logic                wrap;
        logic                span16;
        logic [COL_AW-1:0]   x0;
        logic [SPRITE_W-1:0] bits;
    } row_ctrl_t;

endpackage

// ===== rtl/sfe_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/sfe_row_unit.sv =====
// Row datapath: one shared barrel shifter that places sprite pixels or shifts a row sideways.
// Depends on sfe_pkg.
module sfe_row_unit (
    input  sfe_pkg::row_ctrl_t           ctrl,
    input  logic [sfe_pkg::COLS-1:0]     old_row,
    output logic [sfe_pkg::COLS-1:0]     new_row,
    output logic                         hit
);

    logic [sfe_pkg::SPRITE_W-1:0] sprite_rev;
    logic [sfe_pkg::COLS-1:0]     row_rev;
    logic [sfe_pkg::COLS-1:0]     sh_rev;
    logic [sfe_pkg::COLS-1:0]     mask;
    logic [sfe_pkg::EXT_W-1:0]    sh_in;
    logic [sfe_pkg::EXT_W-1:0]    sh_out;
    logic [sfe_pkg::COL_AW-1:0]   sh_amt;

    // Bit order flips: sprite bit 15 is the leftmost column
    always_comb
    begin
        for (int i = 0; i < sfe_pkg::SPRITE_W; i++)
        begin
            sprite_rev[i] = ctrl.bits[sfe_pkg::SPRITE_W-1-i];
        end
        if (!ctrl.span16)
        begin
            sprite_rev[sfe_pkg::SPRITE_W-1:sfe_pkg::SPRITE_W/2] = '0;
        end
        for (int i = 0; i < sfe_pkg::COLS; i++)
        begin
            row_rev[i] = old_row[sfe_pkg::COLS-1-i];
        end
    end

    // Shared shifter operand select; a left scroll runs through it bit-reversed
    always_comb
    begin
        case (ctrl.op)
            sfe_pkg::ROP_DRAW:
            begin
                sh_in  = {{(sfe_pkg::EXT_W-sfe_pkg::SPRITE_W){1'b0}}, sprite_rev};
                sh_amt = ctrl.x0;
            end
            sfe_pkg::ROP_RIGHT:
            begin
                sh_in  = {{sfe_pkg::SPRITE_W{1'b0}}, old_row};
                sh_amt = sfe_pkg::COL_AW'(sfe_pkg::SIDE_SCROLL);
            end
            sfe_pkg::ROP_LEFT:
            begin
                sh_in  = {{sfe_pkg::SPRITE_W{1'b0}}, row_rev};
                sh_amt = sfe_pkg::COL_AW'(sfe_pkg::SIDE_SCROLL);
            end
            default:
            begin
                sh_in  = {{sfe_pkg::SPRITE_W{1'b0}}, old_row};
                sh_amt = '0;
            end
        endcase
        sh_out = sh_in << sh_amt;
        for (int i = 0; i < sfe_pkg::COLS; i++)
        begin
            sh_rev[i] = sh_out[sfe_pkg::COLS-1-i];
        end
    end

    // Sprite mask: pixels past the right edge fold back to column 0 when wrapping
    always_comb
    begin
        mask = '0;
        if (ctrl.high)
        begin
            mask = sh_out[sfe_pkg::COLS-1:0];
            if (ctrl.wrap)
            begin
                mask[sfe_pkg::SPRITE_W-1:0] = sh_out[sfe_pkg::SPRITE_W-1:0]
                    | sh_out[sfe_pkg::EXT_W-1:sfe_pkg::COLS];
            end
        end
        else
        begin
            mask[sfe_pkg::LOW_COLS-1:0] = sh_out[sfe_pkg::LOW_COLS-1:0];
            if (ctrl.wrap)
            begin
                mask[sfe_pkg::SPRITE_W-1:0] = sh_out[sfe_pkg::SPRITE_W-1:0]
                    | sh_out[sfe_pkg::LOW_COLS+sfe_pkg::SPRITE_W-1:sfe_pkg::LOW_COLS];
            end
        end
    end

    // Result row and collision
    always_comb
    begin
        hit = 1'b0;
        case (ctrl.op)
            sfe_pkg::ROP_DRAW:
            begin
                new_row = old_row ^ mask;
                hit     = |(old_row & mask);
            end
            sfe_pkg::ROP_RIGHT: new_row = sh_out[sfe_pkg::COLS-1:0];
            sfe_pkg::ROP_LEFT:  new_row = sh_rev;
            default:            new_row = old_row;
        endcase
        // low mode keeps the upper half of a row empty
        if (!ctrl.high)
        begin
            new_row[sfe_pkg::COLS-1:sfe_pkg::LOW_COLS] = '0;
        end
    end

endmodule

// ===== rtl/sprite_framebuffer_engine_unit.sv =====
// Top level of the sprite framebuffer engine: command sequencer, row valid bits, row memory.
// Depends on sfe_pkg, sfe_ram and sfe_row_unit.
//
// Usage:
//   A command request is taken at a rising edge with start high and busy low.
//   Exactly one result follows per request: done pulses for one cycle with
//   collision, row_low, row_high and high_res on the ports. The receiver
//   cannot stall; results must be taken in the done cycle.
//   Path from the accepting edge to done:
//     clear, mode change, scroll by zero rows, scroll by the full height,
//     skipped sprite rows and unused codes: no read or write state, done is registered directly.
//     draw row and read row: a read state, then a write state (one memory read;
//     draw also writes the row back). vertical and side scroll: a walk over
//     H = 32 or 64 rows of the row memory, one registered read and one
//     write-back per row, one row after another through the shared row unit.
//   A new request can be taken in the cycle that done is high.
//   clip_mode is written over cfg_valid/cfg_ready while no command is in flight.
//   Reset: screen blank (per-row valid bits cleared, no clearing pass),
//   low mode, collision flag clear, clip_mode 1. The engine is ready at once.
module sprite_framebuffer_engine_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  command,
    input  logic [3:0]  amount,
    input  logic [7:0]  x_pos,
    input  logic [7:0]  y_pos,
    input  logic [3:0]  row_index,
    input  logic [15:0] sprite_bits,
    output logic        done,
    output logic        collision,
    output logic [63:0] row_low,
    output logic [63:0] row_high,
    output logic        high_res,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        clip_mode
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_WR   = 2'd2;

    localparam int RAW = sfe_pkg::ROW_AW;

    logic [1:0]                   state_reg, state_next;
    logic [3:0]                   cmd_reg, cmd_next;
    logic [3:0]                   amount_reg, amount_next;
    logic [RAW-1:0]               row_reg, row_next;
    logic [sfe_pkg::COL_AW-1:0]   x0_reg, x0_next;
    logic [15:0]                  bits_reg, bits_next;
    logic                         span16_reg, span16_next;
    logic                         zero_reg, zero_next;
    logic [sfe_pkg::ROWS-1:0]     valid_reg, valid_next;
    logic                         res_high_reg, res_high_next;
    logic                         coll_reg, coll_next;
    logic                         clip_reg, clip_next;
    logic                         done_reg, done_next;
    logic [63:0]                  row_low_reg, row_low_next;
    logic [63:0]                  row_high_reg, row_high_next;

    logic                         accept;
    logic [RAW-1:0]               h_last;
    logic [RAW:0]                 h_full;
    logic [sfe_pkg::COL_AW-1:0]   x0_in;
    logic [RAW:0]                 y0_in;
    logic [RAW:0]                 y_sum;
    logic [4:0]                   height;
    logic [RAW-1:0]               row_in;
    logic [RAW:0]                 src_wide;
    logic [RAW-1:0]               src;
    logic                         fill;
    logic                         last_row;
    logic                         ram_we;
    logic [sfe_pkg::COLS-1:0]     ram_rdata;
    logic [sfe_pkg::COLS-1:0]     old_row;
    logic [sfe_pkg::COLS-1:0]     new_row;
    logic                         hit;
    sfe_pkg::row_ctrl_t           ctrl;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = !busy;
    assign done      = done_reg;
    assign collision = coll_reg;
    assign high_res  = res_high_reg;
    assign row_low   = row_low_reg;
    assign row_high  = row_high_reg;

    // Geometry of the current mode and decode of a draw request
    always_comb
    begin
        h_last = res_high_reg ? RAW'(sfe_pkg::ROWS - 1) : RAW'(sfe_pkg::LOW_ROWS - 1);
        h_full = res_high_reg ? (RAW+1)'(sfe_pkg::ROWS) : (RAW+1)'(sfe_pkg::LOW_ROWS);
        x0_in  = res_high_reg ? x_pos[sfe_pkg::COL_AW-1:0] : {1'b0, x_pos[5:0]};
        y0_in  = res_high_reg ? {1'b0, y_pos[5:0]} : {2'b00, y_pos[4:0]};
        y_sum  = y0_in + {3'b000, row_index};
        height = (amount == 4'd0) ? 5'd16 : {1'b0, amount};
        row_in = res_high_reg ? y_sum[RAW-1:0] : {1'b0, y_sum[4:0]};
    end

    // Source row of the walk and zero fill for rows scrolled in
    always_comb
    begin
        src_wide = {1'b0, row_reg};
        fill     = 1'b0;
        case (cmd_reg)
            sfe_pkg::CMD_SCROLL_DN:
            begin
                src_wide = {1'b0, row_reg} - {3'b000, amount_reg};
                fill     = ({1'b0, row_reg} < {3'b000, amount_reg});
            end
            sfe_pkg::CMD_SCROLL_UP:
            begin
                src_wide = {1'b0, row_reg} + {3'b000, amount_reg};
                fill     = (src_wide >= h_full);
            end
            default:
            begin
                src_wide = {1'b0, row_reg};
                fill     = 1'b0;
            end
        endcase
        src      = src_wide[RAW-1:0];
        last_row = (cmd_reg == sfe_pkg::CMD_SCROLL_DN) ? (row_reg == '0) : (row_reg == h_last);
    end

    // Row unit control
    always_comb
    begin
        case (cmd_reg)
            sfe_pkg::CMD_DRAW:      ctrl.op = sfe_pkg::ROP_DRAW;
            sfe_pkg::CMD_SCROLL_RT: ctrl.op = sfe_pkg::ROP_RIGHT;
            sfe_pkg::CMD_SCROLL_LT: ctrl.op = sfe_pkg::ROP_LEFT;
            default:                ctrl.op = sfe_pkg::ROP_COPY;
        endcase
        ctrl.high   = res_high_reg;
        ctrl.wrap   = !clip_reg;
        ctrl.span16 = span16_reg;
        ctrl.x0     = x0_reg;
        ctrl.bits   = bits_reg;
        old_row     = zero_reg ? '0 : ram_rdata;
    end

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        amount_next   = amount_reg;
        row_next      = row_reg;
        x0_next       = x0_reg;
        bits_next     = bits_reg;
        span16_next   = span16_reg;
        zero_next     = zero_reg;
        valid_next    = valid_reg;
        res_high_next = res_high_reg;
        coll_next     = coll_reg;
        clip_next     = clip_reg;
        done_next     = 1'b0;
        row_low_next  = '0;
        row_high_next = '0;
        ram_we        = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            clip_next = clip_mode;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = command;
                    amount_next = amount;
                    case (command)
                        sfe_pkg::CMD_CLEAR:
                        begin
                            valid_next = '0;
                            done_next  = 1'b1;
                        end
                        sfe_pkg::CMD_LOW_RES, sfe_pkg::CMD_HIGH_RES:
                        begin
                            valid_next    = '0;
                            res_high_next = (command == sfe_pkg::CMD_HIGH_RES);
                            done_next     = 1'b1;
                        end
                        sfe_pkg::CMD_SCROLL_DN, sfe_pkg::CMD_SCROLL_UP:
                        begin
                            if (amount == 4'd0)
                            begin
                                done_next = 1'b1;
                            end
                            else if ({3'b000, amount} >= h_full)
                            begin
                                valid_next = '0;
                                done_next  = 1'b1;
                            end
                            else
                            begin
                                row_next   = (command == sfe_pkg::CMD_SCROLL_DN) ? h_last : '0;
                                state_next = ST_RD;
                            end
                        end
                        sfe_pkg::CMD_SCROLL_RT, sfe_pkg::CMD_SCROLL_LT:
                        begin
                            row_next   = '0;
                            state_next = ST_RD;
                        end
                        sfe_pkg::CMD_DRAW:
                        begin
                            if (row_index == 4'd0)
                            begin
                                coll_next = 1'b0;
                            end
                            if (({1'b0, row_index} >= height) || ((y_sum >= h_full) && clip_reg))
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                row_next    = row_in;
                                x0_next     = x0_in;
                                bits_next   = sprite_bits;
                                span16_next = (amount == 4'd0) && res_high_reg;
                                state_next  = ST_RD;
                            end
                        end
                        sfe_pkg::CMD_READ:
                        begin
                            row_next   = res_high_reg ? y_pos[RAW-1:0] : {1'b0, y_pos[4:0]};
                            state_next = ST_RD;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_RD:
            begin
                zero_next  = fill || !valid_reg[src];
                state_next = ST_WR;
            end
            ST_WR:
            begin
                case (cmd_reg)
                    sfe_pkg::CMD_READ:
                    begin
                        row_low_next  = old_row[63:0];
                        row_high_next = res_high_reg ? old_row[sfe_pkg::COLS-1:64] : '0;
                        done_next     = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    sfe_pkg::CMD_DRAW:
                    begin
                        ram_we     = 1'b1;
                        coll_next  = coll_reg || hit;
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    default:
                    begin
                        ram_we = 1'b1;
                        if (last_row)
                        begin
                            done_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            row_next   = (cmd_reg == sfe_pkg::CMD_SCROLL_DN) ?
                                         row_reg - 1'b1 : row_reg + 1'b1;
                            state_next = ST_RD;
                        end
                    end
                endcase
                if (ram_we)
                begin
                    valid_next[row_reg] = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cmd_reg      <= sfe_pkg::CMD_CLEAR;
            amount_reg   <= '0;
            row_reg      <= '0;
            x0_reg       <= '0;
            bits_reg     <= '0;
            span16_reg   <= 1'b0;
            zero_reg     <= 1'b1;
            valid_reg    <= '0;
            res_high_reg <= 1'b0;
            coll_reg     <= 1'b0;
            clip_reg     <= 1'b1;
            done_reg     <= 1'b0;
            row_low_reg  <= '0;
            row_high_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cmd_reg      <= cmd_next;
            amount_reg   <= amount_next;
            row_reg      <= row_next;
            x0_reg       <= x0_next;
            bits_reg     <= bits_next;
            span16_reg   <= span16_next;
            zero_reg     <= zero_next;
            valid_reg    <= valid_next;
            res_high_reg <= res_high_next;
            coll_reg     <= coll_next;
            clip_reg     <= clip_next;
            done_reg     <= done_next;
            row_low_reg  <= row_low_next;
            row_high_reg <= row_high_next;
        end
    end

    // Row memory
    sfe_ram #(
        .WIDTH (sfe_pkg::COLS),
        .DEPTH (sfe_pkg::ROWS)
    ) u_rows (
        .clk   (clk),
        .we    (ram_we),
        .waddr (row_reg),
        .wdata (new_row),
        .raddr (src),
        .rdata (ram_rdata)
    );

    // Shared row datapath
    sfe_row_unit u_row_unit (
        .ctrl    (ctrl),
        .old_row (old_row),
        .new_row (new_row),
        .hit     (hit)
    );

    // Checks
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a command is still in flight");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (done || busy))
        else $error("accepted request neither finished nor in flight");

    a_low_mode_high_half: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !high_res) |-> (row_high == '0))
        else $error("upper row half nonzero in low mode");

    a_low_mode_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && !res_high_reg) |-> ({1'b0, row_reg} < (RAW+1)'(sfe_pkg::LOW_ROWS)))
        else $error("row walk left the low mode screen");

    a_write_in_wr: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> (valid_reg[$past(row_reg)] && !(state_reg == ST_WR)))
        else $error("written row not marked valid");

endmodule

// ===== dv/sprite_framebuffer_engine_unit_tb.sv =====
// Self-checking testbench for sprite_framebuffer_engine_unit: a directed table, then random
// sprite sequences, scrolls, mode changes and row reads, checked by an in-bench screen model or pinned values.
// Depends on sfe_pkg and the engine RTL.
module sprite_framebuffer_engine_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [3:0] CMD_UNUSED_LO = sfe_pkg::CMD_READ + 4'd1;
    localparam logic [3:0] CMD_UNUSED_HI = 4'd15;
    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 322;

    typedef struct packed {
        logic [3:0]  command;
        logic [3:0]  amount;
        logic [7:0]  x_pos;
        logic [7:0]  y_pos;
        logic [3:0]  row_index;
        logic [15:0] sprite_bits;
    } screen_req_t;

    typedef struct packed {
        logic        collision;
        logic [63:0] row_low;
        logic [63:0] row_high;
        logic        high_res;
    } screen_result_t;

    typedef struct {
        screen_req_t    rq;
        logic           pinned;
        screen_result_t want;
    } directed_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [3:0]  command;
    logic [3:0]  amount;
    logic [7:0]  x_pos;
    logic [7:0]  y_pos;
    logic [3:0]  row_index;
    logic [15:0] sprite_bits;
    logic        done;
    logic        collision;
    logic [63:0] row_low;
    logic [63:0] row_high;
    logic        high_res;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        clip_mode;

    // Screen model state
    logic [sfe_pkg::COLS-1:0] screen [sfe_pkg::ROWS];
    logic            hires_now;
    logic            flag_now;
    logic            clip_now;

    screen_result_t  pending_results [$];
    directed_row_t   directed_rows [$];
    logic            pin_valid;
    screen_result_t  pin_value;
    logic            idle_on;
    int              issued;
    int              err_count;
    int              cycle_count;

    sprite_framebuffer_engine_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .amount      (amount),
        .x_pos       (x_pos),
        .y_pos       (y_pos),
        .row_index   (row_index),
        .sprite_bits (sprite_bits),
        .done        (done),
        .collision   (collision),
        .row_low     (row_low),
        .row_high    (row_high),
        .high_res    (high_res),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .clip_mode   (clip_mode)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Applies one request to the screen model and returns the result it should produce
    function automatic screen_result_t next_screen_result(input screen_req_t rq);
        screen_result_t  r;
        logic [sfe_pkg::COLS-1:0] row_mask;
        logic [sfe_pkg::COLS-1:0] line;
        int w, h, n, y, x, x0, y0, hgt, span, i;
        r = '0;
        w = hires_now ? sfe_pkg::COLS : sfe_pkg::LOW_COLS;
        h = hires_now ? sfe_pkg::ROWS : sfe_pkg::LOW_ROWS;
        row_mask = hires_now ? {sfe_pkg::COLS{1'b1}}
                             : {{(sfe_pkg::COLS-sfe_pkg::LOW_COLS){1'b0}},
                                {sfe_pkg::LOW_COLS{1'b1}}};
        n = rq.amount;
        case (rq.command)
            sfe_pkg::CMD_CLEAR, sfe_pkg::CMD_LOW_RES, sfe_pkg::CMD_HIGH_RES:
            begin
                for (y = 0; y < sfe_pkg::ROWS; y++) screen[y] = '0;
                if (rq.command == sfe_pkg::CMD_LOW_RES) hires_now = 1'b0;
                if (rq.command == sfe_pkg::CMD_HIGH_RES) hires_now = 1'b1;
            end
            sfe_pkg::CMD_SCROLL_DN:
            begin
                for (y = h - 1; y >= 0; y--) screen[y] = (y >= n) ? screen[y-n] : '0;
            end
            sfe_pkg::CMD_SCROLL_UP:
            begin
                for (y = 0; y < h; y++) screen[y] = (y + n < h) ? screen[y+n] : '0;
            end
            sfe_pkg::CMD_SCROLL_RT:
            begin
                for (y = 0; y < h; y++)
                    screen[y] = (screen[y] << sfe_pkg::SIDE_SCROLL) & row_mask;
            end
            sfe_pkg::CMD_SCROLL_LT:
            begin
                for (y = 0; y < h; y++)
                    screen[y] = (screen[y] >> sfe_pkg::SIDE_SCROLL) & row_mask;
            end
            sfe_pkg::CMD_DRAW:
            begin
                x0 = rq.x_pos & (w - 1);
                y0 = rq.y_pos & (h - 1);
                hgt = (n == 0) ? 16 : n;
                span = (n == 0 && hires_now) ? 16 : 8;
                if (rq.row_index == 0) flag_now = 1'b0;
                y = y0 + rq.row_index;
                // rows past the sprite height, or clipped off the bottom, do nothing
                if (rq.row_index < hgt && !(y >= h && clip_now))
                begin
                    y = y & (h - 1);
                    for (i = 0; i < span; i++)
                    begin
                        x = x0 + i;
                        if (rq.sprite_bits[15-i] && !(x >= w && clip_now))
                        begin
                            x = x & (w - 1);
                            if (screen[y][x]) flag_now = 1'b1;
                            screen[y][x] = ~screen[y][x];
                        end
                    end
                end
            end
            sfe_pkg::CMD_READ:
            begin
                line = screen[rq.y_pos & (h - 1)] & row_mask;
                r.row_low = line[63:0];
                r.row_high = hires_now ? line[127:64] : 64'd0;
            end
            default: ;
        endcase
        r.collision = flag_now;
        r.high_res = hires_now;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            err_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    // Result checking, request capture and clip register tracking
    always @(posedge clk)
    begin : watch_results
        screen_result_t got;
        screen_result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                got = {collision, row_low, row_high, high_res};
                if (pending_results.size() == 0)
                begin
                    err_count++;
                    $display("%0t: result with no request outstanding, actual %h", $time, got);
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("collision", want.collision, got.collision);
                    check_field("row_low", want.row_low, got.row_low);
                    check_field("row_high", want.row_high, got.row_high);
                    check_field("high_res", want.high_res, got.high_res);
                end
            end
            if (start && !busy)
            begin
                want = next_screen_result({command, amount, x_pos, y_pos, row_index,
                                           sprite_bits});
                pending_results.push_back(pin_valid ? pin_value : want);
            end
            if (cfg_valid && cfg_ready) clip_now = clip_mode;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Drives one request at the falling edge and holds it until accepted
    task automatic issue(input screen_req_t rq, input logic pin, input screen_result_t want);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        start <= 1'b1;
        command <= rq.command;
        amount <= rq.amount;
        x_pos <= rq.x_pos;
        y_pos <= rq.y_pos;
        row_index <= rq.row_index;
        sprite_bits <= rq.sprite_bits;
        pin_valid <= pin;
        pin_value <= want;
        do @(posedge clk); while (busy);
        @(negedge clk);
        if (rq.command <= sfe_pkg::CMD_READ) issued++;
    endtask

    task automatic write_clip(input logic value);
        cfg_valid <= 1'b1;
        clip_mode <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_row(input logic [3:0] cmd, input logic [3:0] amt, input logic [7:0] x,
                           input logic [7:0] y, input logic [3:0] ri, input logic [15:0] bits,
                           input logic pin, input logic coll, input logic [63:0] lo,
                           input logic hr);
        directed_row_t d;
        d.rq = {cmd, amt, x, y, ri, bits};
        d.pinned = pin;
        d.want = {coll, lo, 64'd0, hr};
        directed_rows.push_back(d);
    endtask

    initial
    begin : stimulus
        screen_req_t rq;
        logic [7:0]  base_y;
        int          phase, kind, hgt, ri_end, k, target;
        for (k = 0; k < sfe_pkg::ROWS; k++) screen[k] = '0;
        hires_now = 1'b0;
        flag_now = 1'b0;
        clip_now = 1'b1;
        err_count = 0;
        cycle_count = 0;
        issued = 0;
        idle_on = 1'b1;
        rst_n = 1'b0;
        start = 1'b0;
        command = sfe_pkg::CMD_CLEAR;
        amount = '0;
        x_pos = '0;
        y_pos = '0;
        row_index = '0;
        sprite_bits = '0;
        cfg_valid = 1'b0;
        clip_mode = 1'b1;
        pin_valid = 1'b0;
        pin_value = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // Directed table: blank screen, collision, masking of rows, edge clipping,
        // 16-wide sprites, rows past height and bottom, every scroll, unused codes
        add_row(sfe_pkg::CMD_READ,      4'd0,  8'd0,   8'd0,   4'd0,  16'h0000, 1, 0, 64'h0, 0);
        add_row(CMD_UNUSED_HI,          4'd15, 8'd255, 8'd255, 4'd15, 16'hFFFF, 1, 0, 64'h0, 0);
        add_row(sfe_pkg::CMD_DRAW,      4'd1,  8'd0,   8'd0,   4'd0,  16'h8000, 1, 0, 64'h0, 0);
        add_row(sfe_pkg::CMD_READ,      4'd0,  8'd0,   8'd0,   4'd0,  16'h0000, 1, 0, 64'h1, 0);
        add_row(sfe_pkg::CMD_DRAW,      4'd1,  8'd0,   8'd0,   4'd0,  16'h8000, 1, 1, 64'h0, 0);
        add_row(sfe_pkg::CMD_READ,      4'd0,  8'd0,   8'd32,  4'd0,  16'h0000, 1, 1, 64'h0, 0);
        add_row(sfe_pkg::CMD_DRAW,      4'd15, 8'd255, 8'd255, 4'd0,  16'hFFFF, 1, 0, 64'h0, 0);
        add_row(sfe_pkg::CMD_READ,      4'd0,  8'd0,   8'd31,  4'd0,  16'h0000, 1, 0,
                64'h8000_0000_0000_0000, 0);
        add_row(sfe_pkg::CMD_SCROLL_RT, 4'd0,  8'd0,   8'd0,   4'd0,  16'h0000, 0, 0, 64'h0, 0);
        add_row(sfe_pkg::CMD_READ,      4'd0,  8'd0,   8'd31,  4'd0,  16'h0000, 0, 0, 64'h0, 0);
        add_row(sfe_pkg::CMD_HIGH_RES,  4'd0,  8'd0,   8'd0,   4'd0,  16'h0000, 1, 0, 64'h0, 1);
        add_row(sfe_pkg::CMD_DRAW,      4'd0,  8'd120, 8'd60,  4'd0,  16'hFFFF, 0, 0, 64'h0, 0);
        add_row(sfe_pkg::CMD_DRAW,      4'd0,  8'd120, 8'd60,  4'd4,  16'hFFFF, 0, 0, 64'h0, 0);
        add_row(sfe_pkg::CMD_DRAW,      4'd3,  8'd10,  8'd10,  4'd15, 16'hFFFF, 0, 0, 64'h0, 0);
        add_row(sfe_pkg::CMD_READ,      4'd0,  8'd0,   8'd60,  4'd0,  16'h0000, 0, 0, 64'h0, 0);
        add_row(sfe_pkg::CMD_SCROLL_DN, 4'd0,  8'd0,   8'd0,   4'd0,  16'h0000, 0, 0, 64'h0, 0);
        add_row(sfe_pkg::CMD_SCROLL_UP, 4'd15, 8'd0,   8'd0,   4'd0,  16'h0000, 0, 0, 64'h0, 0);
        add_row(sfe_pkg::CMD_READ,      4'd0,  8'd0,   8'd45,  4'd0,  16'h0000, 0, 0, 64'h0, 0);
        add_row(sfe_pkg::CMD_SCROLL_LT, 4'd0,  8'd0,   8'd0,   4'd0,  16'h0000, 0, 0, 64'h0, 0);
        add_row(sfe_pkg::CMD_SCROLL_DN, 4'd15, 8'd0,   8'd0,   4'd0,  16'h0000, 0, 0, 64'h0, 0);
        add_row(sfe_pkg::CMD_READ,      4'd0,  8'd0,   8'd60,  4'd0,  16'h0000, 0, 0, 64'h0, 0);
        add_row(sfe_pkg::CMD_CLEAR,     4'd0,  8'd0,   8'd0,   4'd0,  16'h0000, 0, 0, 64'h0, 0);
        add_row(CMD_UNUSED_LO,          4'd0,  8'd0,   8'd0,   4'd0,  16'h0000, 0, 0, 64'h0, 0);
        add_row(sfe_pkg::CMD_LOW_RES,   4'd0,  8'd0,   8'd0,   4'd0,  16'h0000, 0, 0, 64'h0, 0);
        foreach (directed_rows[i]) issue(directed_rows[i].rq, directed_rows[i].pinned,
                                         directed_rows[i].want);

        // Random phases, each under its own clip setting; the last one runs without gaps
        target = issued;
        for (phase = 0; phase < PHASES; phase++)
        begin
            start <= 1'b0;
            while (pending_results.size() != 0) @(negedge clk);
            write_clip(phase == 0 ? 1'b0 : (phase == 1 ? 1'b1 : 1'($urandom_range(0, 1))));
            idle_on = (phase != PHASES - 1);
            target += ITEMS_PER_PHASE;
            while (issued < target)
            begin
                kind = $urandom_range(0, 99);
                rq = {4'($urandom), 4'($urandom), 8'($urandom), 8'($urandom), 4'($urandom),
                      16'($urandom)};
                if (kind < 55)
                begin
                    // Well-formed sprite: rows 0..height-1, sometimes cut short or overrun
                    rq.command = sfe_pkg::CMD_DRAW;
                    if ($urandom_range(0, 3) == 0) rq.x_pos = 8'hF0 | 8'($urandom_range(0, 15));
                    if ($urandom_range(0, 3) == 0) rq.y_pos = 8'hF0 | 8'($urandom_range(0, 15));
                    base_y = rq.y_pos;
                    hgt = (rq.amount == 0) ? 16 : rq.amount;
                    ri_end = hgt;
                    if ($urandom_range(0, 9) == 0) ri_end = $urandom_range(1, hgt);
                    else if (hgt < 16 && $urandom_range(0, 7) == 0) ri_end = hgt + 1;
                    for (k = 0; k < ri_end; k++)
                    begin
                        rq.row_index = 4'(k);
                        rq.sprite_bits = 16'($urandom);
                        issue(rq, 1'b0, '0);
                    end
                    // look at what was just drawn
                    if ($urandom_range(0, 1) == 1)
                    begin
                        rq.command = sfe_pkg::CMD_READ;
                        repeat ($urandom_range(1, 3))
                        begin
                            rq.y_pos = base_y + 8'($urandom_range(0, 15));
                            issue(rq, 1'b0, '0);
                        end
                    end
                end
                else
                begin
                    if (kind < 78) rq.command = sfe_pkg::CMD_READ;
                    else if (kind < 86) rq.command = $urandom_range(0, 1)
                                                     ? sfe_pkg::CMD_SCROLL_DN
                                                     : sfe_pkg::CMD_SCROLL_UP;
                    else if (kind < 90) rq.command = $urandom_range(0, 1)
                                                     ? sfe_pkg::CMD_SCROLL_RT
                                                     : sfe_pkg::CMD_SCROLL_LT;
                    else if (kind < 92) rq.command = sfe_pkg::CMD_CLEAR;
                    else if (kind < 94) rq.command = sfe_pkg::CMD_LOW_RES;
                    else if (kind < 96) rq.command = sfe_pkg::CMD_HIGH_RES;
                    else if (kind < 98) rq.command = sfe_pkg::CMD_DRAW;
                    else rq.command = 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
                    issue(rq, 1'b0, '0);
                end
            end
        end

        // Drain and finish
        start <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/sfe_pkg.sv
rtl/sfe_ram.sv
rtl/sfe_row_unit.sv
rtl/sprite_framebuffer_engine_unit.sv
dv/sprite_framebuffer_engine_unit_tb.sv
